@@ src/fdia_pkg.sv @@
`default_nettype none
package fdia_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned CAPACITY_DEF      = 1024;
  localparam int unsigned PENDING_DEPTH_DEF = 64;

  // Fixed field widths.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned FENCE_W = 64;

  localparam logic [CNT_W-1:0] CNT_MAX         = 7'h7F;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 11'd1024;

  // Register index taken from the word address.
  localparam logic REG_MAX_ENTRIES = 1'b0;

  // Request modes.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_RECLAIM = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_POOL_FULL  = 2'd1;
  localparam logic [1:0] ST_QUEUE_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  // Commands from the top level to the pending queue.
  typedef struct packed {
    logic               push;
    logic               walk;
    logic [FENCE_W-1:0] fence;
  } pq_ctrl_t;

  // Status from the pending queue to the top level.
  typedef struct packed {
    logic full;
    logic empty;
    logic retire;
    logic done;
  } pq_stat_t;

endpackage
`default_nettype wire

@@ src/fdia_pend.sv @@
`default_nettype none
// Pending release queue. Entries hold a slot index and its fence. A walk
// reads one entry per cycle, reports retired entries, and compacts the rest.
module fdia_pend #(
  parameter int unsigned DEPTH = fdia_pkg::PENDING_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire fdia_pkg::pq_ctrl_t          ctrl,
  input  wire  [fdia_pkg::IDX_W-1:0]       push_slot,
  input  wire                              free_full,
  output fdia_pkg::pq_stat_t               stat,
  output logic [fdia_pkg::IDX_W-1:0]       retire_slot
);

  localparam int unsigned PCW = $clog2(DEPTH + 1);
  localparam int unsigned PAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW  = fdia_pkg::IDX_W + fdia_pkg::FENCE_W;

  logic [EW-1:0]                  mem [DEPTH];
  logic [EW-1:0]                  q;
  logic [PCW-1:0]                 count, count_next;
  logic [PCW-1:0]                 rd, rd_next;
  logic [PCW-1:0]                 wr, wr_next;
  logic                           walking, walking_next;
  logic [fdia_pkg::FENCE_W-1:0]   cmp_fence;
  logic [fdia_pkg::FENCE_W-1:0]   q_fence;
  logic                           retire, last;
  logic                           rd_en, we;
  logic [PAW-1:0]                 rd_addr, wr_addr;
  logic [EW-1:0]                  wr_data;

  assign retire_slot = q[EW-1 -: fdia_pkg::IDX_W];
  assign q_fence     = q[fdia_pkg::FENCE_W-1:0];
  assign retire      = walking && (q_fence <= cmp_fence) && !free_full;
  assign last        = walking && (rd == count);

  assign stat.full   = (count == PCW'(DEPTH));
  assign stat.empty  = (count == '0);
  assign stat.retire = retire;
  assign stat.done   = last;

  // Reads run one entry ahead of the compare; writes only go to places
  // already read, so the walk never overwrites an entry it still needs.
  always_comb begin
    count_next   = count;
    rd_next      = rd;
    wr_next      = wr;
    walking_next = walking;
    rd_en        = 1'b0;
    rd_addr      = rd[PAW-1:0];
    we           = 1'b0;
    wr_addr      = wr[PAW-1:0];
    wr_data      = q;
    if (ctrl.push) begin
      we         = 1'b1;
      wr_addr    = count[PAW-1:0];
      wr_data    = {push_slot, ctrl.fence};
      count_next = count + PCW'(1);
    end else if (ctrl.walk) begin
      rd_en        = 1'b1;
      rd_addr      = '0;
      rd_next      = PCW'(1);
      wr_next      = '0;
      walking_next = 1'b1;
    end else if (walking) begin
      if (!retire) begin
        we      = 1'b1;
        wr_next = wr + PCW'(1);
      end
      if (last) begin
        walking_next = 1'b0;
        count_next   = wr_next;
      end else begin
        rd_en   = 1'b1;
        rd_next = rd + PCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd      <= '0;
      wr      <= '0;
      walking <= 1'b0;
    end else begin
      count   <= count_next;
      rd      <= rd_next;
      wr      <= wr_next;
      walking <= walking_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.walk) begin
      cmp_fence <= ctrl.fence;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/fence_deferred_index_allocator.sv @@
`default_nettype none
// Timing: a fresh allocate, a release or the unused mode gives done in the cycle after the
// request; a pop from the free stack gives it after state S_ALLOC and the done register.
// Reclaim gives done once the walk has read each entry; an empty queue acts as a release.
// Throughput: one request per cycle for simple cases; pop and reclaim keep busy high
// until done, the walk reading one pending entry per cycle. The receiver cannot stall.
// Reset (rst, synchronous) clears free, fresh and queue counts; max_entries goes to 1024.
module fence_deferred_index_allocator #(
  parameter int unsigned CAPACITY      = fdia_pkg::CAPACITY_DEF,
  parameter int unsigned PENDING_DEPTH = fdia_pkg::PENDING_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // Request channel
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        mode,
  input  wire  [fdia_pkg::IDX_W-1:0]        release_index,
  input  wire                               handle_valid,
  input  wire  [fdia_pkg::FENCE_W-1:0]      fence_value,
  // Result channel
  output logic                              done,
  output logic [1:0]                        status,
  output logic [fdia_pkg::IDX_W-1:0]        granted_index,
  output logic [fdia_pkg::CNT_W-1:0]        reclaimed_count,
  // Configuration port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [2:0]                        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Width of the free count and the fresh index counter, which both reach CAPACITY.
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned FAW = $clog2(CAPACITY);
  localparam int unsigned LW  = (CW > fdia_pkg::CFG_W) ? CW : fdia_pkg::CFG_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_WALK  = 3'b100
  } state_t;

  state_t                        state, state_next;
  logic [fdia_pkg::CFG_W-1:0]    max_entries;
  logic [CW-1:0]                 free_count, free_count_next, free_dec;
  logic [CW-1:0]                 next_fresh, next_fresh_next;
  logic [fdia_pkg::CNT_W-1:0]    moved, moved_next;
  logic                          done_next;
  logic [1:0]                    status_next;
  logic [fdia_pkg::IDX_W-1:0]    granted_next;
  logic [fdia_pkg::CNT_W-1:0]    reclaimed_next;
  logic                          accept, fresh_ok, free_full, fs_rd_en, cfg_wr;
  logic [fdia_pkg::IDX_W-1:0]    fs_mem [CAPACITY];
  logic [fdia_pkg::IDX_W-1:0]    fs_q;
  logic [fdia_pkg::IDX_W-1:0]    retire_slot;
  fdia_pkg::pq_ctrl_t            pq_ctrl;
  fdia_pkg::pq_stat_t            pq_stat;

  // ---------------------------------------------------------------------
  // Configuration: a single 11-bit register at word 0, read zero-extended to 32 bits.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == fdia_pkg::REG_MAX_ENTRIES) ? 32'(max_entries) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= fdia_pkg::MAX_ENTRIES_RST;
    end else if (cfg_wr && (paddr[2] == fdia_pkg::REG_MAX_ENTRIES)) begin
      max_entries <= pwdata[fdia_pkg::CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Request handling. Simple requests finish in the accept cycle and leave
  // the block idle, so a new request can follow at once. A stack pop waits
  // in state S_ALLOC for the memory read; a reclaim walks the pending queue.
  // ---------------------------------------------------------------------
  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign free_full = (free_count == CW'(CAPACITY));
  assign free_dec  = free_count - CW'(1);
  // The fresh index must stay below both the register and the capacity.
  assign fresh_ok  = (LW'(next_fresh) < LW'(max_entries)) && (next_fresh < CW'(CAPACITY));

  always_comb begin
    state_next      = state;
    free_count_next = free_count;
    next_fresh_next = next_fresh;
    moved_next      = moved;
    done_next       = 1'b0;
    status_next     = fdia_pkg::ST_OK;
    granted_next    = '0;
    reclaimed_next  = '0;
    fs_rd_en        = 1'b0;
    pq_ctrl.push    = 1'b0;
    pq_ctrl.walk    = 1'b0;
    pq_ctrl.fence   = fence_value;
    case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (mode)
            fdia_pkg::MODE_ALLOC: begin
              if (free_count != '0) begin
                fs_rd_en        = 1'b1;
                free_count_next = free_dec;
                done_next       = 1'b0;
                state_next      = S_ALLOC;
              end else if (fresh_ok) begin
                granted_next    = fdia_pkg::IDX_W'(next_fresh);
                next_fresh_next = next_fresh + CW'(1);
              end else begin
                status_next = fdia_pkg::ST_POOL_FULL;
              end
            end
            fdia_pkg::MODE_RELEASE: begin
              // The handle check takes priority over the queue-full check.
              if (!handle_valid) begin
                status_next = fdia_pkg::ST_BAD_HANDLE;
              end else if (pq_stat.full) begin
                status_next = fdia_pkg::ST_QUEUE_FULL;
              end else begin
                pq_ctrl.push = 1'b1;
              end
            end
            fdia_pkg::MODE_RECLAIM: begin
              // An empty queue finishes at once with a count of zero.
              if (!pq_stat.empty) begin
                pq_ctrl.walk = 1'b1;
                moved_next   = '0;
                done_next    = 1'b0;
                state_next   = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALLOC: begin
        done_next    = 1'b1;
        granted_next = fs_q;
        state_next   = S_IDLE;
      end
      S_WALK: begin
        // A retired entry is pushed onto the free stack in the same cycle.
        if (pq_stat.retire) begin
          free_count_next = free_count + CW'(1);
          moved_next      = (moved == fdia_pkg::CNT_MAX) ? moved : moved + fdia_pkg::CNT_W'(1);
        end
        if (pq_stat.done) begin
          done_next      = 1'b1;
          reclaimed_next = moved_next;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      next_fresh <= '0;
      moved      <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      free_count <= free_count_next;
      next_fresh <= next_fresh_next;
      moved      <= moved_next;
      done       <= done_next;
    end
  end

  // Result payload; only meaningful while done is high.
  always_ff @(posedge clk) begin
    status          <= status_next;
    granted_index   <= granted_next;
    reclaimed_count <= reclaimed_next;
  end

  // ---------------------------------------------------------------------
  // Free stack memory: one write port for reclaim, one read port for pop.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (pq_stat.retire) begin
      fs_mem[free_count[FAW-1:0]] <= retire_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (fs_rd_en) begin
      fs_q <= fs_mem[free_dec[FAW-1:0]];
    end
  end

  fdia_pend #(
    .DEPTH (PENDING_DEPTH)
  ) u_pend (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pq_ctrl),
    .push_slot   (release_index),
    .free_full   (free_full),
    .stat        (pq_stat),
    .retire_slot (retire_slot)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == fdia_pkg::MODE_ALLOC) && (free_count != '0)) |=> (state == S_ALLOC))
    else $error("stack pop did not wait for the read");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC) |=> (done && (status == fdia_pkg::ST_OK)))
    else $error("stack pop gave no ok result");

  a_retire_push: assert property (@(posedge clk) disable iff (rst)
    pq_stat.retire |=> (free_count == $past(free_count) + CW'(1)))
    else $error("retired entry not counted on the free stack");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(state != S_IDLE)))
    else $error("result without a request");

endmodule
`default_nettype wire
